// ----- sv/acl_pkg.sv -----
// Shared widths, payload types and datapath control for the autocorrelation unit.
package acl_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 2 * SAMPLE_W;
  localparam int unsigned LAG_W    = 6;
  localparam int unsigned VALUE_W  = 42;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [LAG_W-1:0]           lag_t;

  // Control from the sequencer to the multiply-accumulate datapath
  typedef struct packed {
    logic clear;  // zero the accumulator at the start of a lag
    logic valid;  // operand pair from the store is present this cycle
  } mac_ctrl_t;

endpackage

// ----- sv/acl_ifs.sv -----
// Valid/ready channel interfaces for sample input and result output.
interface acl_sample_if;
  logic              valid;
  logic              ready;
  acl_pkg::sample_t  sample;
  logic              last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface acl_result_if;
  logic             valid;
  logic             ready;
  acl_pkg::lag_t    lag;
  acl_pkg::value_t  value;
  logic             last_result;

  modport source (output valid, output lag, output value, output last_result, input ready);
  modport sink   (input valid, input lag, input value, input last_result, output ready);
endinterface

// ----- sv/acl_store.sv -----
// Sample memory: one write port, two registered read ports.
module acl_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  acl_pkg::sample_t         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output acl_pkg::sample_t         rd_data_a,
  output acl_pkg::sample_t         rd_data_b
);

  acl_pkg::sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- sv/acl_mac.sv -----
// Registered multiply followed by a 42-bit accumulator.
module acl_mac (
  input  logic               clk,
  input  logic               rst,
  input  acl_pkg::mac_ctrl_t ctrl,
  input  acl_pkg::sample_t   a,
  input  acl_pkg::sample_t   b,
  output acl_pkg::value_t    acc,
  output logic               busy
);

  acl_pkg::prod_t prod;
  logic           prod_valid;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(acl_pkg::VALUE_W - acl_pkg::PROD_W){prod[acl_pkg::PROD_W-1]}}, prod};
    end
  end

  assign busy = prod_valid;

endmodule

// ----- sv/autocorrelation_all_lags_unit.sv -----
// Top level of the biased autocorrelation unit over all lags of a sample set.
//
// Samples (signed Q1.15) arrive one transaction at a time and are written to an
// internal store; a sample flagged last_sample, or the sample that fills the
// store to DEPTH entries, closes the set. The unit then emits one result
// transaction per lag, lag 0 up to N-1 for a set of N samples, each value being
// the exact sum of x[i]*x[i+lag] over i with i+lag < N (Q12.30, 42-bit two's
// complement); last_result marks lag N-1. Samples are not taken while the
// results of a set are being computed. Each sample of the set is loaded in
// turn; lag k then issues N-k products, after which the values drain through
// the read/multiply/accumulate pipeline and the sum is handed to the output
// register. The pace is set by the single multiplier fed by the two read
// ports of the sample memory, one product per cycle while the pairs of a lag
// are read. The output register lets the next set start loading while the
// final result of the previous set still waits to be taken.
module autocorrelation_all_lags_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  acl_sample_if.sink   samples,
  acl_result_if.source results
);

  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,  // loading samples into the store
    ST_ISSUE   = 3'b010,  // reading operand pairs for the current lag
    ST_FLUSH   = 3'b100   // draining the pipeline, then handing off the result
  } state_t;

  state_t             state;
  logic [AW-1:0]      count;     // next write address while collecting
  logic [AW-1:0]      last_idx;  // index of the final sample of the set
  logic [AW-1:0]      lag;
  logic [AW-1:0]      idx;
  logic               rd_valid;

  logic               sample_take;
  logic               set_done;
  logic [AW-1:0]      addr_b;
  logic               pipe_empty;
  logic               out_free;
  logic               emit;
  logic               final_lag;

  acl_pkg::sample_t   rd_data_a;
  acl_pkg::sample_t   rd_data_b;
  acl_pkg::value_t    acc;
  logic               mac_busy;
  acl_pkg::mac_ctrl_t mac_ctrl;

  // Output register
  logic               out_valid;
  acl_pkg::lag_t      out_lag;
  acl_pkg::value_t    out_value;
  logic               out_last;

  assign samples.ready = (state == ST_COLLECT);
  assign sample_take   = samples.valid && samples.ready;
  assign set_done      = samples.last_sample || (count == AW'(DEPTH - 1));

  assign addr_b     = idx + lag;
  assign pipe_empty = !rd_valid && !mac_busy;
  assign out_free   = !out_valid || results.ready;
  assign emit       = (state == ST_FLUSH) && pipe_empty && out_free;
  assign final_lag  = (lag == last_idx);

  // Accumulator restarts whenever a lag begins
  assign mac_ctrl.clear = (sample_take && set_done) || (emit && !final_lag);
  assign mac_ctrl.valid = rd_valid;

  acl_store #(.DEPTH(DEPTH)) u_store (
    .clk      (clk),
    .wr_en    (sample_take),
    .wr_addr  (count),
    .wr_data  (samples.sample),
    .rd_addr_a(idx),
    .rd_addr_b(addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  acl_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctrl(mac_ctrl),
    .a   (rd_data_a),
    .b   (rd_data_b),
    .acc (acc),
    .busy(mac_busy)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_ISSUE);
      case (state)
        ST_COLLECT: begin
          if (sample_take) begin
            if (set_done) begin
              last_idx <= count;
              count    <= '0;
              lag      <= '0;
              idx      <= '0;
              state    <= ST_ISSUE;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          // Last pair of this lag once the far operand reaches the final sample
          if (addr_b == last_idx) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (emit) begin
            if (final_lag) begin
              state <= ST_COLLECT;
            end else begin
              lag   <= lag + 1'b1;
              idx   <= '0;
              state <= ST_ISSUE;
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // Result register: loaded on hand-off, cleared when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_lag   <= acl_pkg::LAG_W'(lag);
      out_value <= acc;
      out_last  <= final_lag;
    end
  end

  assign results.valid       = out_valid;
  assign results.lag         = out_lag;
  assign results.value       = out_value;
  assign results.last_result = out_last;

endmodule

// ----- tb/acl_lag_sum_check.sv -----
// Scoreboard for the autocorrelation unit: rebuilds each sample set, predicts lag sums, checks results.
module acl_lag_sum_check
  import acl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  acl_sample_if       samples,
  acl_result_if       results,
  output int unsigned errors,
  output int unsigned pending
);

  typedef struct packed {
    lag_t   lag;
    value_t value;
    logic   last_result;
  } lag_sum_t;

  sample_t     set_store [DEPTH];
  int          set_len = 0;
  lag_sum_t    sums_due [$];
  int unsigned err_count = 0;
  int unsigned due_count = 0;

  assign errors  = err_count;
  assign pending = due_count;

  task automatic report(input string what);
    $display("[%0t] lag sum mismatch: %s", $time, what);
    err_count++;
  endtask

  // Set is complete: queue one exact sum per lag, lag 0 first
  function automatic void close_set();
    lag_sum_t sum;
    longint   acc;
    for (int k = 0; k < set_len; k++) begin
      acc = 0;
      for (int i = 0; i + k < set_len; i++)
        acc += longint'(set_store[i]) * longint'(set_store[i + k]);
      sum.lag         = lag_t'(k);
      sum.value       = value_t'(acc);
      sum.last_result = (k + 1 == set_len);
      sums_due.push_back(sum);
    end
    set_len = 0;
  endfunction

  always @(posedge clk) begin
    lag_sum_t want;
    if (rst) begin
      set_len = 0;
      sums_due.delete();
    end else begin
      if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
        set_store[set_len] = samples.sample;
        set_len++;
        if (samples.last_sample || set_len == DEPTH)
          close_set();
      end
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        if (sums_due.size() == 0) begin
          report($sformatf("unexpected result lag %0d value %0d",
                           results.lag, results.value));
        end else begin
          want = sums_due.pop_front();
          if (results.lag !== want.lag)
            report($sformatf("lag %0d, want %0d", results.lag, want.lag));
          if (results.value !== want.value)
            report($sformatf("lag %0d value %0d, want %0d",
                             want.lag, results.value, want.value));
          if (results.last_result !== want.last_result)
            report($sformatf("lag %0d last_result %b, want %b",
                             want.lag, results.last_result, want.last_result));
        end
      end
    end
    due_count = sums_due.size();
  end

endmodule

// ----- tb/tb_autocorrelation_all_lags_unit.sv -----
// Testbench top: sample set stimulus, result back-pressure and the verdict for the unit.
module tb_autocorrelation_all_lags_unit;
  import acl_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned ITEMS        = 410;  // sample transactions to send in all
  localparam int unsigned CALM_FROM    = 350;  // no idling on either side from here on
  localparam int unsigned HOLD_CYCLES  = 600;  // long result stall to back the unit up
  localparam int unsigned DRAIN_CYCLES = 200;  // quiet time after the last expected result
  // Limit for the whole run in time units (clock period of 4), meant to cover
  // the slowest run (all full sets, every gap and stall at its longest).
  localparam longint      LIMIT_TIME   = 800000;

  // Flavour of the sample values within one set
  typedef enum int unsigned {
    MIX_EXTREME,
    MIX_SMALL,
    MIX_FULL
  } mix_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned errors;
  int unsigned pending;

  int unsigned sent     = 0;     // sample transactions accepted so far
  bit          calm     = 1'b0;  // final stretch: no idling anywhere
  bit          gappy    = 1'b0;  // sender may idle between samples of this set
  int unsigned hold_req = 0;     // long result stall requested by the sender side

  acl_sample_if samples_ch ();
  acl_result_if results_ch ();

  autocorrelation_all_lags_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .results(results_ch)
  );

  // Watches both channels, predicts every lag sum and counts mismatches
  acl_lag_sum_check #(
    .DEPTH(DEPTH)
  ) sum_check (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .results(results_ch),
    .errors (errors),
    .pending(pending)
  );

  always #2 clk = ~clk;

  // Offer one sample and hold it until the unit takes it. Valid stays high
  // into the next call unless an idle burst follows, so it is never dropped
  // and raised in the same step.
  task automatic put_sample(input sample_t x, input logic mark);
    samples_ch.valid       <= 1'b1;
    samples_ch.sample      <= x;
    samples_ch.last_sample <= mark;
    @(posedge clk);
    while (samples_ch.ready !== 1'b1) @(posedge clk);
    sent++;
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic sample_t pick_sample(input mix_e mix);
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          3:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      MIX_SMALL: return sample_t'(int'($urandom_range(0, 15)) - 8);
      default:   return sample_t'($urandom);
    endcase
  endfunction

  // A set of len samples; the final one carries mark_end. A full set closes
  // on its own whatever the mark says.
  task automatic put_set(input int unsigned len, input mix_e mix, input logic mark_end);
    for (int unsigned i = 0; i < len; i++)
      put_sample(pick_sample(mix), (i == len - 1) ? mark_end : 1'b0);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic wait_drained();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random ready with stall bursts, long hold-offs on request,
  // always ready in the final stretch.
  initial begin : result_sink
    results_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        results_ch.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        results_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned set_no;
    int unsigned len;
    logic        mark_end;
    mix_e        mix;

    samples_ch.valid       <= 1'b0;
    samples_ch.sample      <= '0;
    samples_ch.last_sample <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample sets at the extremes, short sets mixing the
    // most negative and most positive samples, then a set of four most negative ones.
    put_sample(16'sh8000, 1'b1);
    put_sample(16'sh7FFF, 1'b1);
    put_sample(16'sh0000, 1'b1);
    put_sample(16'sh8000, 1'b0);
    put_sample(16'sh7FFF, 1'b1);
    put_sample(16'sh7FFF, 1'b0);
    put_sample(16'sh8000, 1'b0);
    put_sample(-16'sd1, 1'b0);
    put_sample(16'sd1, 1'b0);
    put_sample(16'sh8000, 1'b1);
    for (int i = 0; i < 4; i++)
      put_sample(16'sh8000, (i == 3));
    // sender pause: nothing new until the unit has emptied
    wait_drained();

    // Random sets, mostly short, some filling the store outright
    set_no = 0;
    while (sent < ITEMS) begin
      if (sent >= CALM_FROM)
        calm = 1'b1;
      gappy = ($urandom_range(0, 2) != 0);
      mix   = mix_e'($urandom_range(0, 2));
      if (set_no == 2)
        hold_req = HOLD_CYCLES;  // results stall while sets keep coming
      if (set_no == 6)
        wait_drained();
      if (set_no == 0 || set_no == 9 || $urandom_range(0, 24) == 0) begin
        len      = DEPTH;
        mark_end = ($urandom_range(0, 1) != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        len      = DEPTH - 1;
        mark_end = 1'b1;
      end else begin
        len      = $urandom_range(1, 12);
        mark_end = 1'b1;
      end
      put_set(len, mix, mark_end);
      set_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_autocorrelation_all_lags_unit: clean");
    else
      $display("tb_autocorrelation_all_lags_unit: errors");
    $finish;
  end

  // Watchdog: a hung handshake or missing result ends the run here
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("tb_autocorrelation_all_lags_unit: errors");
    $finish;
  end

endmodule

// ----- autocorrelation_all_lags_unit.f -----
sv/acl_pkg.sv
sv/acl_ifs.sv
sv/acl_store.sv
sv/acl_mac.sv
sv/autocorrelation_all_lags_unit.sv
tb/acl_lag_sum_check.sv
tb/tb_autocorrelation_all_lags_unit.sv
